/* hw/rtl/htfd_pkg.sv */
// Shared types, constants and the CRC-8 byte step for the frame decoder.
`default_nettype none
package htfd_pkg;

  localparam int QUEUE_DEPTH = 2;

  // byte position codes
  localparam logic [2:0] POS_FIRST = 3'd1;
  localparam logic [2:0] POS_CRC   = 3'd6;
  localparam logic [2:0] POS_IDLE  = 3'd7;

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  localparam logic [7:0] STAT_BUSY = 8'h80;
  localparam logic [7:0] STAT_CAL  = 8'h18;

  localparam int RAW_W   = 20;
  localparam int HPROD_W = 30;
  localparam int TPROD_W = 31;
  localparam int TEMP_W  = 32;

  localparam logic [HPROD_W-1:0] HUM_SCALE   = 30'd1000;
  localparam logic [TPROD_W-1:0] TEMP_SCALE  = 31'd2000;
  localparam logic signed [TEMP_W-1:0] TEMP_OFFSET = 32'sd524288000;  // 500 * 2^20
  localparam logic signed [TEMP_W-1:0] FRAC_MASK   = 32'sd1048575;    // 2^20 - 1

  // one decoded frame handed from front to back
  typedef struct packed {
    logic             crc_ok;
    logic             busy;
    logic             calibrated;
    logic [RAW_W-1:0] hum_raw;
    logic [RAW_W-1:0] tmp_raw;
  } job_t;

  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) c = {c[6:0], 1'b0} ^ CRC_POLY;
      else      c = {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* hw/rtl/htfd_front.sv */
// Front end: takes reply bytes, tracks position and CRC, emits a job per full frame.
`default_nettype none
module htfd_front (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        accept,
  input  wire logic [7:0]  data_byte,
  input  wire logic        frame_start,
  output logic             push,
  output htfd_pkg::job_t   push_job
);

  logic [2:0]  pos_r, pos_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [7:0]  status_r, status_nxt;
  logic [39:0] payload_r, payload_nxt;
  logic        in_data, in_crc;

  assign in_data = (pos_r >= htfd_pkg::POS_FIRST) && (pos_r < htfd_pkg::POS_CRC);
  assign in_crc  = (pos_r == htfd_pkg::POS_CRC);

  always_comb begin
    pos_nxt     = pos_r;
    crc_nxt     = crc_r;
    status_nxt  = status_r;
    payload_nxt = payload_r;
    push        = 1'b0;
    if (accept) begin
      if (frame_start) begin
        status_nxt = data_byte;
        crc_nxt    = htfd_pkg::crc8_step(htfd_pkg::CRC_INIT, data_byte);
        pos_nxt    = htfd_pkg::POS_FIRST;
      end else if (in_data) begin
        payload_nxt = {payload_r[31:0], data_byte};
        crc_nxt     = htfd_pkg::crc8_step(crc_r, data_byte);
        pos_nxt     = pos_r + 3'd1;
      end else if (in_crc) begin
        push    = 1'b1;
        pos_nxt = htfd_pkg::POS_IDLE;
      end
    end
  end

  always_comb begin
    push_job.crc_ok     = (crc_r == data_byte);
    push_job.busy       = |(status_r & htfd_pkg::STAT_BUSY);
    push_job.calibrated = ((status_r & htfd_pkg::STAT_CAL) == htfd_pkg::STAT_CAL);
    push_job.hum_raw    = payload_r[39:20];
    push_job.tmp_raw    = payload_r[19:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= htfd_pkg::POS_IDLE;
      crc_r    <= htfd_pkg::CRC_INIT;
      status_r <= 8'd0;
    end else begin
      pos_r    <= pos_nxt;
      crc_r    <= crc_nxt;
      status_r <= status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    payload_r <= payload_nxt;
  end

endmodule
`default_nettype wire

/* hw/rtl/htfd_queue.sv */
// Small job queue between front and back ends.
`default_nettype none
module htfd_queue #(
  parameter int DEPTH = htfd_pkg::QUEUE_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire htfd_pkg::job_t push_job,
  input  wire logic           pop,
  output logic                full,
  output logic                not_empty,
  output htfd_pkg::job_t      head_job
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  htfd_pkg::job_t mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic do_push, do_pop;

  function automatic logic [AW-1:0] bump(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head_job  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? bump(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? bump(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop)      count_nxt = count_r + CW'(1);
    else if (do_pop && !do_push) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_job;
  end

endmodule
`default_nettype wire

/* hw/rtl/htfd_back.sv */
// Back end: scales raw words to tenths in two stages and holds the result.
`default_nettype none
module htfd_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              job_valid,
  input  wire htfd_pkg::job_t    job,
  output logic                   job_ready,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic                   out_crc_ok,
  output logic                   out_sensor_busy,
  output logic                   out_sensor_calibrated,
  output logic [9:0]             out_humidity_tenths,
  output logic signed [11:0]     out_temperature_tenths
);

  logic s1_valid_r, s1_ready, s2_ready, out_valid_r;
  logic s1_crc_r, s1_busy_r, s1_cal_r;
  logic [htfd_pkg::HPROD_W-1:0] hprod_r, hprod_nxt;
  logic [htfd_pkg::TPROD_W-1:0] tprod_r, tprod_nxt;
  logic signed [htfd_pkg::TEMP_W-1:0] tnum, tadj;
  logic crc_r, busy_r, cal_r;
  logic [9:0] hum_r;
  logic signed [11:0] temp_r;

  assign s2_ready  = !out_valid_r || !out_stall;
  assign s1_ready  = !s1_valid_r || s2_ready;
  assign job_ready = s1_ready;

  assign hprod_nxt = htfd_pkg::HPROD_W'(job.hum_raw) * htfd_pkg::HUM_SCALE;
  assign tprod_nxt = htfd_pkg::TPROD_W'(job.tmp_raw) * htfd_pkg::TEMP_SCALE;

  // truncate toward zero: bias negatives by 2^20-1 before the shift
  assign tnum = $signed({1'b0, tprod_r}) - htfd_pkg::TEMP_OFFSET;
  assign tadj = tnum + (tnum[htfd_pkg::TEMP_W-1] ? htfd_pkg::FRAC_MASK : '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_r <= job_valid;
      if (s2_ready) out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && job_valid) begin
      s1_crc_r  <= job.crc_ok;
      s1_busy_r <= job.busy;
      s1_cal_r  <= job.calibrated;
      hprod_r   <= hprod_nxt;
      tprod_r   <= tprod_nxt;
    end
    if (s2_ready && s1_valid_r) begin
      crc_r  <= s1_crc_r;
      busy_r <= s1_busy_r;
      cal_r  <= s1_cal_r;
      hum_r  <= hprod_r[29:20];
      temp_r <= tadj[31:20];
    end
  end

  assign out_valid              = out_valid_r;
  assign out_crc_ok             = crc_r;
  assign out_sensor_busy        = busy_r;
  assign out_sensor_calibrated  = cal_r;
  assign out_humidity_tenths    = hum_r;
  assign out_temperature_tenths = temp_r;

endmodule
`default_nettype wire

/* hw/rtl/humidity_temperature_frame_decoder_top.sv */
// Top level of the humidity/temperature reply frame decoder.
//
// Input channel: one reply byte per request (in_data_byte), in_frame_start
// marks the status byte and always restarts the frame. Bytes outside a frame
// are dropped. A byte is taken on any cycle with in_valid high, in_stall low.
// Result channel: one request per completed seven-byte frame carrying the
// CRC check, busy and calibrated bits, humidity and temperature in tenths.
// Throughput: one byte per cycle unless in_stall is high; the CRC byte step
// is combinational. After the CRC byte is taken the job passes the job queue,
// the multiply stage and then the output register.
// A receiver stall holds the output register; frames keep decoding into the
// job queue, and in_stall rises only while that queue is full.
// Reset (synchronous, active low) clears the position to idle, the CRC to
// its initial value, empties the queue and drops any pending result.
`default_nettype none
module humidity_temperature_frame_decoder_top #(
  parameter int QUEUE_DEPTH = htfd_pkg::QUEUE_DEPTH
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    in_data_byte,
  input  wire logic          in_frame_start,
  output logic               out_valid,
  input  wire logic          out_stall,
  output logic               out_crc_ok,
  output logic               out_sensor_busy,
  output logic               out_sensor_calibrated,
  output logic [9:0]         out_humidity_tenths,
  output logic signed [11:0] out_temperature_tenths
);

  htfd_pkg::job_t push_job, head_job;
  logic push, full, not_empty, job_ready, accept;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  htfd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .data_byte   (in_data_byte),
    .frame_start (in_frame_start),
    .push        (push),
    .push_job    (push_job)
  );

  htfd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (job_ready),
    .full      (full),
    .not_empty (not_empty),
    .head_job  (head_job)
  );

  htfd_back u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .job_valid              (not_empty),
    .job                    (head_job),
    .job_ready              (job_ready),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_crc_ok             (out_crc_ok),
    .out_sensor_busy        (out_sensor_busy),
    .out_sensor_calibrated  (out_sensor_calibrated),
    .out_humidity_tenths    (out_humidity_tenths),
    .out_temperature_tenths (out_temperature_tenths)
  );

endmodule
`default_nettype wire

/* hw/rtl/htfd_checker.sv */
// Port-level checks for the frame decoder, bound to the top level.
`default_nettype none
module htfd_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic              out_crc_ok,
  input wire logic              out_sensor_busy,
  input wire logic              out_sensor_calibrated,
  input wire logic [9:0]        out_humidity_tenths,
  input wire logic signed [11:0] out_temperature_tenths
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_crc_ok) &&
    $stable(out_sensor_busy) && $stable(out_sensor_calibrated) &&
    $stable(out_humidity_tenths) && $stable(out_temperature_tenths))
    else $error("stalled result changed");

  // reset empties the queue and the output register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("pending state after reset");

  a_hum_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_humidity_tenths <= 10'd999)
    else $error("humidity out of range");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_temperature_tenths >= -12'sd500) &&
                  (out_temperature_tenths <= 12'sd1499))
    else $error("temperature out of range");

endmodule

bind humidity_temperature_frame_decoder_top htfd_checker u_htfd_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .in_stall               (in_stall),
  .out_valid              (out_valid),
  .out_stall              (out_stall),
  .out_crc_ok             (out_crc_ok),
  .out_sensor_busy        (out_sensor_busy),
  .out_sensor_calibrated  (out_sensor_calibrated),
  .out_humidity_tenths    (out_humidity_tenths),
  .out_temperature_tenths (out_temperature_tenths)
);
`default_nettype wire

/* tb/tb_humidity_temperature_frame_decoder_top.sv */
// Testbench for the humidity/temperature frame decoder: random reply frames, self-checking.
module tb_humidity_temperature_frame_decoder_top;

  localparam int RANDOM_BYTES = 1500;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum int {PH_SLOW_SINK, PH_SLOW_SOURCE, PH_FULL_RATE} pace_t;

  typedef struct {
    logic [7:0] data;
    logic       start;
    pace_t      pace;
    bit         drain;  // hold this request until every reading is back
  } reply_byte_t;

  typedef struct {
    logic               crc_ok;
    logic               busy;
    logic               calibrated;
    logic [9:0]         humidity;
    logic signed [11:0] temperature;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] in_data_byte = 8'h00;
  logic in_frame_start = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_crc_ok;
  logic out_sensor_busy;
  logic out_sensor_calibrated;
  logic [9:0] out_humidity_tenths;
  logic signed [11:0] out_temperature_tenths;

  humidity_temperature_frame_decoder_top dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_data_byte          (in_data_byte),
    .in_frame_start        (in_frame_start),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_crc_ok            (out_crc_ok),
    .out_sensor_busy       (out_sensor_busy),
    .out_sensor_calibrated (out_sensor_calibrated),
    .out_humidity_tenths   (out_humidity_tenths),
    .out_temperature_tenths(out_temperature_tenths)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  reply_byte_t reply_bytes[$];
  reading_t    pending_readings[$];
  pace_t       gen_pace = PH_SLOW_SINK;
  pace_t       cur_pace = PH_SLOW_SINK;
  int          frame_bytes_gen = 0;
  int          mismatch_count = 0;
  int          cycle_count = 0;
  logic        in_took = 1'b0;

  // decoder state as seen by the checker
  logic [7:0]  dec_crc = htfd_pkg::CRC_INIT;
  logic [2:0]  dec_pos = htfd_pkg::POS_IDLE;
  logic [7:0]  dec_status = 8'h00;
  logic [39:0] dec_payload = 40'h0;

  function automatic logic [7:0] crc_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic       fb;
    c = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = c[7] ^ b[i];
      c = {c[6:0], 1'b0};
      if (fb) c = c ^ htfd_pkg::CRC_POLY;
    end
    return c;
  endfunction

  function automatic int idle_pct(input pace_t p, input bit sender);
    case (p)
      PH_SLOW_SINK:   return sender ? 38 : 81;
      PH_SLOW_SOURCE: return sender ? 81 : 38;
      default:        return 0;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic decode_reply_byte(input logic [7:0] b, input logic s);
    reading_t    r;
    logic [19:0] hum_raw;
    logic [19:0] tmp_raw;
    logic [63:0] hum_prod;
    longint      tmp_num;
    if (s) begin
      dec_status = b;
      dec_crc = crc_next(htfd_pkg::CRC_INIT, b);
      dec_pos = htfd_pkg::POS_FIRST;
    end else if (dec_pos == htfd_pkg::POS_IDLE) begin
      // outside a frame: dropped
    end else if (dec_pos < htfd_pkg::POS_CRC) begin
      dec_payload = {dec_payload[31:0], b};
      dec_crc = crc_next(dec_crc, b);
      dec_pos++;
    end else begin
      hum_raw = dec_payload[39:20];
      tmp_raw = dec_payload[19:0];
      hum_prod = 64'(hum_raw) * 64'd1000;
      // signed division truncates toward zero
      tmp_num = longint'(tmp_raw) * 2000 - 64'sd524288000;
      r.crc_ok = (dec_crc == b);
      r.busy = (dec_status & htfd_pkg::STAT_BUSY) != 8'h00;
      r.calibrated = (dec_status & htfd_pkg::STAT_CAL) == htfd_pkg::STAT_CAL;
      r.humidity = 10'(hum_prod >> 20);
      r.temperature = 12'(tmp_num / 1048576);
      pending_readings.push_back(r);
      dec_pos = htfd_pkg::POS_IDLE;
    end
  endtask

  task automatic check_reading();
    reading_t e;
    if (pending_readings.size() == 0) begin
      report_mismatch("result with no reading expected");
      return;
    end
    e = pending_readings.pop_front();
    if (out_crc_ok !== e.crc_ok)
      report_mismatch($sformatf("crc_ok %b, expected %b", out_crc_ok, e.crc_ok));
    if (out_sensor_busy !== e.busy)
      report_mismatch($sformatf("busy %b, expected %b", out_sensor_busy, e.busy));
    if (out_sensor_calibrated !== e.calibrated)
      report_mismatch($sformatf("calibrated %b, expected %b",
                                out_sensor_calibrated, e.calibrated));
    if (out_humidity_tenths !== e.humidity)
      report_mismatch($sformatf("humidity %0d, expected %0d",
                                out_humidity_tenths, e.humidity));
    if (out_temperature_tenths !== e.temperature)
      report_mismatch($sformatf("temperature %0d, expected %0d",
                                out_temperature_tenths, e.temperature));
  endtask

  task automatic push_byte(input logic [7:0] d, input logic s, input bit drain);
    reply_byte_t rb;
    rb.data = d;
    rb.start = s;
    rb.pace = gen_pace;
    rb.drain = drain;
    reply_bytes.push_back(rb);
  endtask

  // len < 7 cuts the frame short
  task automatic push_frame(input logic [7:0] st, input logic [39:0] pl, input bit good_crc,
                            input int len, input bit drain);
    logic [7:0] c;
    c = crc_next(htfd_pkg::CRC_INIT, st);
    for (int i = 0; i < 5; i++) c = crc_next(c, pl[39-8*i -: 8]);
    if (!good_crc) c = c ^ 8'($urandom_range(1, 255));
    push_byte(st, 1'b1, drain);
    for (int i = 0; i < 5; i++)
      if (i + 1 < len) push_byte(pl[39-8*i -: 8], 1'b0, 1'b0);
    if (len >= 7) push_byte(c, 1'b0, 1'b0);
    frame_bytes_gen += (len > 7) ? 7 : len;
  endtask

  // request driver
  always @(negedge clk) begin
    reply_byte_t rb;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_took) begin
      // stalled: hold the request
    end else if (reply_bytes.size() == 0) begin
      in_valid <= 1'b0;
    end else if (reply_bytes[0].drain && pending_readings.size() != 0) begin
      in_valid <= 1'b0;
    end else if ($urandom_range(99) < idle_pct(reply_bytes[0].pace, 1'b1)) begin
      in_valid <= 1'b0;
    end else begin
      rb = reply_bytes.pop_front();
      in_valid <= 1'b1;
      in_data_byte <= rb.data;
      in_frame_start <= rb.start;
      cur_pace <= rb.pace;
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < idle_pct(cur_pace, 1'b0));
  end

  always @(posedge clk) begin
    if (rst_n) begin
      in_took <= in_valid && !in_stall;
      if (in_valid && !in_stall) decode_reply_byte(in_data_byte, in_frame_start);
      if (out_valid && !out_stall) check_reading();
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int    r;
    int    len;
    bit    drain;
    pace_t last_pace;
    logic [39:0] pl;

    // directed: idle noise, extremes, restart mid-frame, bad CRC at zero crossing
    push_byte(8'hA5, 1'b0, 1'b0);
    push_frame(8'h00, 40'h00_0000_0000, 1'b1, 7, 1'b0);
    push_frame(8'hFF, 40'hFF_FFFF_FFFF, 1'b1, 7, 1'b0);
    push_frame(8'h18, 40'h12_3456_789A, 1'b1, 3, 1'b0);
    push_frame(8'h98, {20'h80000, 20'h40000}, 1'b0, 7, 1'b0);
    push_byte(8'h3C, 1'b0, 1'b0);

    last_pace = gen_pace;
    while (frame_bytes_gen < RANDOM_BYTES + 25) begin
      gen_pace = (frame_bytes_gen < 525) ? PH_SLOW_SINK :
                 (frame_bytes_gen < 1025) ? PH_SLOW_SOURCE : PH_FULL_RATE;
      drain = (gen_pace != last_pace) || ($urandom_range(39) == 0);
      last_pace = gen_pace;
      pl = {8'($urandom), 32'($urandom)};
      if ($urandom_range(9) == 0)
        for (int i = 0; i < 5; i++) pl[8*i +: 8] = $urandom_range(1) ? 8'hFF : 8'h00;
      r = $urandom_range(99);
      if (r < 78) begin
        push_frame(8'($urandom), pl, $urandom_range(4) != 0, 7, drain);
      end else if (r < 90) begin
        len = $urandom_range(1, 6);
        push_frame(8'($urandom), pl, 1'b1, len, drain);
      end else begin
        // stray bytes: dropped when idle, else they extend a cut frame
        len = $urandom_range(1, 3);
        for (int i = 0; i < len; i++) push_byte(8'($urandom), 1'b0, 1'b0);
      end
    end

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    while (reply_bytes.size() != 0 || in_valid || pending_readings.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
